// File: design/lcbcc_pkg.sv
// Shared types, constants and the sequencer program store for the load-cell
// balance to control-change converter. No dependencies.
package lcbcc_pkg;

   // Field and storage widths.
   localparam int unsigned CellWidth   = 16;
   localparam int unsigned SumWidth    = 18;
   localparam int unsigned CcWidth     = 7;
   localparam int unsigned ValueWidth  = 7;
   localparam int unsigned ChanWidth   = 5;
   localparam int unsigned CsrWidth    = 28;
   localparam int unsigned DivWidth    = 24;
   localparam int unsigned PcWidth     = 5;
   localparam int unsigned NumSlots    = 7;
   localparam int unsigned SlotWidth   = 3;

   // Behavior constants.
   localparam logic [SumWidth-1:0]   MinTotal    = 18'd100;
   localparam logic [7:0]            NothingSent = 8'hFF;
   localparam logic [CsrWidth-1:0]   ResetCorner = '0;
   localparam logic [CcWidth-1:0]    ResetTotal  = 7'd40;
   localparam logic [CcWidth-1:0]    ResetX      = 7'd41;
   localparam logic [CcWidth-1:0]    ResetY      = 7'd42;
   localparam logic [CellWidth-1:0]  ResetScale  = 16'd40000;
   localparam logic [ChanWidth-1:0]  ResetChan   = 5'd1;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_BOARD_ENABLE = 3'd0,
      CSR_CORNER_CC    = 3'd1,
      CSR_TOTAL_CC     = 3'd2,
      CSR_X_CC         = 3'd3,
      CSR_Y_CC         = 3'd4,
      CSR_FULL_SCALE   = 3'd5,
      CSR_CHANNEL      = 3'd6
   } csr_index_type;

   // Output slots, in message order.
   typedef enum logic [SlotWidth-1:0] {
      SLOT_TL    = 3'd0,
      SLOT_TR    = 3'd1,
      SLOT_BL    = 3'd2,
      SLOT_BR    = 3'd3,
      SLOT_TOTAL = 3'd4,
      SLOT_X     = 3'd5,
      SLOT_Y     = 3'd6
   } slot_type;

   // Microcode operations.
   typedef enum logic [2:0] {
      OP_WAIT   = 3'd0,  // take a report when one is offered
      OP_LOAD   = 3'd1,  // set up divider operands for the slot
      OP_DIV    = 3'd2,  // one quotient bit a cycle, holds until done
      OP_LIGHT  = 3'd3,  // jump to target when the total is light
      OP_EMIT   = 3'd4,  // send the slot's message if it is due
      OP_JUMP   = 3'd5   // unconditional jump to target
   } op_type;

   typedef struct packed {
      op_type                 op;
      slot_type               slot;
      logic [PcWidth-1:0]     target;
   } ctl_word_type;

   localparam logic [PcWidth-1:0] PcEmitStart = 5'd16;
   localparam logic [PcWidth-1:0] PcIdle      = 5'd0;

   function automatic ctl_word_type program_word(input logic [PcWidth-1:0] pc);
      ctl_word_type w;
      w = '{op: OP_JUMP, slot: SLOT_TL, target: PcIdle};
      case (pc)
         5'd0:  w = '{op: OP_WAIT,  slot: SLOT_TL,    target: PcIdle};
         5'd1:  w = '{op: OP_LOAD,  slot: SLOT_TL,    target: PcIdle};
         5'd2:  w = '{op: OP_DIV,   slot: SLOT_TL,    target: PcIdle};
         5'd3:  w = '{op: OP_LOAD,  slot: SLOT_TR,    target: PcIdle};
         5'd4:  w = '{op: OP_DIV,   slot: SLOT_TR,    target: PcIdle};
         5'd5:  w = '{op: OP_LOAD,  slot: SLOT_BL,    target: PcIdle};
         5'd6:  w = '{op: OP_DIV,   slot: SLOT_BL,    target: PcIdle};
         5'd7:  w = '{op: OP_LOAD,  slot: SLOT_BR,    target: PcIdle};
         5'd8:  w = '{op: OP_DIV,   slot: SLOT_BR,    target: PcIdle};
         5'd9:  w = '{op: OP_LOAD,  slot: SLOT_TOTAL, target: PcIdle};
         5'd10: w = '{op: OP_DIV,   slot: SLOT_TOTAL, target: PcIdle};
         5'd11: w = '{op: OP_LIGHT, slot: SLOT_TL,    target: PcEmitStart};
         5'd12: w = '{op: OP_LOAD,  slot: SLOT_X,     target: PcIdle};
         5'd13: w = '{op: OP_DIV,   slot: SLOT_X,     target: PcIdle};
         5'd14: w = '{op: OP_LOAD,  slot: SLOT_Y,     target: PcIdle};
         5'd15: w = '{op: OP_DIV,   slot: SLOT_Y,     target: PcIdle};
         5'd16: w = '{op: OP_EMIT,  slot: SLOT_TL,    target: PcIdle};
         5'd17: w = '{op: OP_EMIT,  slot: SLOT_TR,    target: PcIdle};
         5'd18: w = '{op: OP_EMIT,  slot: SLOT_BL,    target: PcIdle};
         5'd19: w = '{op: OP_EMIT,  slot: SLOT_BR,    target: PcIdle};
         5'd20: w = '{op: OP_EMIT,  slot: SLOT_TOTAL, target: PcIdle};
         5'd21: w = '{op: OP_EMIT,  slot: SLOT_X,     target: PcIdle};
         5'd22: w = '{op: OP_EMIT,  slot: SLOT_Y,     target: PcIdle};
         default: w = '{op: OP_JUMP, slot: SLOT_TL,   target: PcIdle};
      endcase
      return w;
   endfunction

endpackage

// File: design/load_cell_balance_to_cc.sv
// Top level of the load-cell balance to control-change converter.
// Depends on lcbcc_pkg for widths, register indexes and the microcode program.

// One report of four load-cell readings becomes up to seven MIDI control-change
// words, sent in the order top-left, top-right, bottom-left, bottom-right,
// total, left/right balance and front/back balance. A word goes out only when
// its controller number is nonzero and its value differs from the last value
// sent for that output; the final word of a report carries last_of_run. The
// balance outputs are only considered while the total is above 100; under a
// light load the two balance divisions are skipped. A due word waits while the
// result side is stalled. The single shared divider produces one quotient bit
// per cycle, seven bits plus one setup step per output, walked through by a
// small microcoded sequencer. A new report is taken only when the sequencer is
// back at its wait step. With board_enable clear, reports are taken and dropped.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle, which the block itself does not enforce.
module load_cell_balance_to_cc
   import lcbcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CellWidth-1:0]  req_top_left,
   input  logic [CellWidth-1:0]  req_top_right,
   input  logic [CellWidth-1:0]  req_bottom_left,
   input  logic [CellWidth-1:0]  req_bottom_right,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CcWidth-1:0]    rsp_controller_number,
   output logic [ValueWidth-1:0] rsp_control_value,
   output logic [ChanWidth-1:0]  rsp_channel,
   output logic                  rsp_last_of_run,

   input  logic                  csr_write_enable,
   input  logic [2:0]            csr_index,
   input  logic [CsrWidth-1:0]   csr_write_data
);

   // Configuration registers.
   logic                  board_enable_ff;
   logic [CsrWidth-1:0]   corner_cc_ff;
   logic [CcWidth-1:0]    sum_cc_ff;
   logic [CcWidth-1:0]    x_cc_ff;
   logic [CcWidth-1:0]    y_cc_ff;
   logic [CellWidth-1:0]  full_scale_ff;
   logic [ChanWidth-1:0]  channel_ff;

   // Sequencer and datapath state.
   logic [PcWidth-1:0]    pc_ff, pc_in;
   logic [CellWidth-1:0]  cell_ff [4];
   logic [CellWidth-1:0]  cell_in [4];
   logic [SumWidth-1:0]   sum_ff, sum_in;
   logic                  heavy_ff, heavy_in;
   logic [DivWidth-1:0]   rem_ff, rem_in;
   logic [DivWidth-1:0]   dsh_ff, dsh_in;
   logic [ValueWidth-1:0] quot_ff, quot_in;
   logic [2:0]            bit_cnt_ff, bit_cnt_in;
   logic [ValueWidth-1:0] value_ff [NumSlots];
   logic [ValueWidth-1:0] value_in [NumSlots];
   logic [7:0]            last_ff [NumSlots];
   logic [7:0]            last_in [NumSlots];

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CcWidth-1:0]    rsp_cc_ff, rsp_cc_in;
   logic [ValueWidth-1:0] rsp_value_ff, rsp_value_in;
   logic [ChanWidth-1:0]  rsp_chan_ff, rsp_chan_in;
   logic                  rsp_last_ff, rsp_last_in;

   ctl_word_type          ctl;
   logic [CcWidth-1:0]    slot_cc [NumSlots];
   logic [NumSlots-1:0]   due;
   logic [NumSlots-1:0]   later_due;
   logic                  out_free;

   // Divider operand setup.
   logic [SumWidth-1:0]   op_num;
   logic [SumWidth-1:0]   op_lim;
   logic [SumWidth-1:0]   op_clamped;
   logic [SumWidth+6:0]   op_times;
   logic [DivWidth-1:0]   trial;
   logic                  trial_ok;

   assign ctl = program_word(pc_ff);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         board_enable_ff <= 1'b0;
         corner_cc_ff    <= ResetCorner;
         sum_cc_ff       <= ResetTotal;
         x_cc_ff         <= ResetX;
         y_cc_ff         <= ResetY;
         full_scale_ff   <= ResetScale;
         channel_ff      <= ResetChan;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BOARD_ENABLE: board_enable_ff <= csr_write_data[0];
            CSR_CORNER_CC:    corner_cc_ff    <= csr_write_data;
            CSR_TOTAL_CC:     sum_cc_ff       <= csr_write_data[CcWidth-1:0];
            CSR_X_CC:         x_cc_ff         <= csr_write_data[CcWidth-1:0];
            CSR_Y_CC:         y_cc_ff         <= csr_write_data[CcWidth-1:0];
            CSR_FULL_SCALE:   full_scale_ff   <= csr_write_data[CellWidth-1:0];
            CSR_CHANNEL:      channel_ff      <= csr_write_data[ChanWidth-1:0];
            default: ;
         endcase
      end
   end

   // Controller number of each slot.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         slot_cc[i] = corner_cc_ff[i*CcWidth +: CcWidth];
      end
      slot_cc[SLOT_TOTAL] = sum_cc_ff;
      slot_cc[SLOT_X]     = x_cc_ff;
      slot_cc[SLOT_Y]     = y_cc_ff;
   end

   // A slot is due when it has a controller, a new value, and (for the
   // balance outputs) the load is heavy enough. later_due flags whether any
   // slot after this one will still send, which decides last_of_run.
   always_comb begin
      for (int i = 0; i < NumSlots; i++) begin
         due[i] = (slot_cc[i] != '0) && ({1'b0, value_ff[i]} != last_ff[i])
                  && ((i < int'(SLOT_X)) || heavy_ff);
      end
      later_due[NumSlots-1] = 1'b0;
      for (int i = NumSlots - 2; i >= 0; i--) begin
         later_due[i] = later_due[i+1] | due[i+1];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the slot being loaded. A zero limit turns into
   // 0 divided by 1 so that the quotient comes out as zero.
   always_comb begin
      op_num = '0;
      op_lim = '0;
      case (ctl.slot)
         SLOT_TL, SLOT_TR, SLOT_BL, SLOT_BR: begin
            op_num = {2'b00, cell_ff[ctl.slot[1:0]]};
            op_lim = {4'b0000, full_scale_ff[CellWidth-1:2]};
         end
         SLOT_TOTAL: begin
            op_num = sum_ff;
            op_lim = {2'b00, full_scale_ff};
         end
         SLOT_X: begin
            op_num = SumWidth'(cell_ff[2'(SLOT_TR)]) + SumWidth'(cell_ff[2'(SLOT_BR)]);
            op_lim = sum_ff;
         end
         SLOT_Y: begin
            op_num = SumWidth'(cell_ff[2'(SLOT_TL)]) + SumWidth'(cell_ff[2'(SLOT_TR)]);
            op_lim = sum_ff;
         end
         default: ;
      endcase
      op_clamped = (op_num > op_lim) ? op_lim : op_num;
      op_times   = {op_clamped, 7'b0000000} - {7'b0000000, op_clamped};
   end

   assign trial_ok = rem_ff >= dsh_ff;
   assign trial    = rem_ff - dsh_ff;

   // Sequencer: executes one control word per cycle.
   always_comb begin
      pc_in        = pc_ff;
      cell_in      = cell_ff;
      sum_in       = sum_ff;
      heavy_in     = heavy_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quot_in      = quot_ff;
      bit_cnt_in   = bit_cnt_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cc_in    = rsp_cc_ff;
      rsp_value_in = rsp_value_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (ctl.op)
         OP_WAIT: begin
            if (req_valid) begin
               cell_in[2'(SLOT_TL)] = req_top_left;
               cell_in[2'(SLOT_TR)] = req_top_right;
               cell_in[2'(SLOT_BL)] = req_bottom_left;
               cell_in[2'(SLOT_BR)] = req_bottom_right;
               sum_in = SumWidth'(req_top_left) + SumWidth'(req_top_right)
                        + SumWidth'(req_bottom_left) + SumWidth'(req_bottom_right);
               heavy_in = sum_in > MinTotal;
               if (board_enable_ff) begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         OP_LOAD: begin
            if (op_lim == '0) begin
               rem_in = '0;
               dsh_in = DivWidth'(1) << (ValueWidth - 1);
            end else begin
               rem_in = op_times[DivWidth-1:0];
               dsh_in = {op_lim, 6'b000000};
            end
            quot_in    = '0;
            bit_cnt_in = 3'(ValueWidth - 1);
            pc_in      = pc_ff + 1'b1;
         end
         OP_DIV: begin
            rem_in     = trial_ok ? trial : rem_ff;
            dsh_in     = dsh_ff >> 1;
            quot_in    = {quot_ff[ValueWidth-2:0], trial_ok};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               value_in[ctl.slot] = quot_in;
               pc_in = pc_ff + 1'b1;
            end
         end
         OP_LIGHT: begin
            pc_in = heavy_ff ? pc_ff + 1'b1 : ctl.target;
         end
         OP_EMIT: begin
            if (!due[ctl.slot]) begin
               pc_in = pc_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_cc_in        = slot_cc[ctl.slot];
               rsp_value_in     = value_ff[ctl.slot];
               rsp_chan_in      = channel_ff;
               rsp_last_in      = !later_due[ctl.slot];
               last_in[ctl.slot] = {1'b0, value_ff[ctl.slot]};
               pc_in = pc_ff + 1'b1;
            end
         end
         OP_JUMP: begin
            pc_in = ctl.target;
         end
         default: pc_in = PcIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PcIdle;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NumSlots; i++) begin
            last_ff[i] <= NothingSent;
         end
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff      <= cell_in;
      sum_ff       <= sum_in;
      heavy_ff     <= heavy_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quot_ff      <= quot_in;
      bit_cnt_ff   <= bit_cnt_in;
      value_ff     <= value_in;
      rsp_cc_ff    <= rsp_cc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall             = ctl.op != OP_WAIT;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_controller_number = rsp_cc_ff;
   assign rsp_control_value     = rsp_value_ff;
   assign rsp_channel           = rsp_chan_ff;
   assign rsp_last_of_run       = rsp_last_ff;

endmodule
